// ===== hdl/bounded_two_key_priority_queue_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the two-key priority queue
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_TWO_KEY_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define BOUNDED_TWO_KEY_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BTKPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BTKPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/btkpq_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-key priority queue package
// Word types, entry layout, status codes and defaults shared by the queue.
// ----------------------------------------------------------------------------
package btkpq_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int CAP_W           = 5;
  localparam int OCC_W           = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_t;

  typedef struct packed {
    logic [15:0] seq;
    logic [7:0]  key;
    logic [7:0]  id;
  } entry_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  entry_id;
    logic [7:0]  entry_key;
    logic [15:0] entry_seq;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       out_id;
    logic [7:0]       out_key;
    logic [15:0]      out_seq;
    logic [OCC_W-1:0] occupancy;
  } out_word_t;

  // Per-cycle command broadcast to every cell of the row.
  typedef struct packed {
    logic ins_en;
    logic rem_en;
  } cell_ctrl_t;

endpackage

// ===== hdl/bounded_two_key_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// Bounded two-key priority queue core
// A row of cells kept sorted by key (descending), sequence (ascending) and
// arrival order; inserts slide into place, removes pop the head.
//
//   channel   direction  handshake            word
//   in_       input      in_valid / in_stall  btkpq_pkg::in_word_t
//   out_      output     out_valid / out_stall btkpq_pkg::out_word_t
//   cfg_      input      cfg_we               cfg_data (capacity)
//
// One word is taken per cycle while in_stall is low; its result is registered
// and shown the cycle after acceptance. All cells update the store at once,
// so the compare in each cell and the shift to its neighbor set the period.
// Synchronous reset empties the queue and sets capacity to 16.
// in_stall rises only while a result is held and out_stall is high.
// ----------------------------------------------------------------------------
`include "bounded_two_key_priority_queue_core_defines.svh"

module bounded_two_key_priority_queue_core #(
  parameter int MAX_ENTRIES = btkpq_pkg::MAX_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  btkpq_pkg::in_word_t          in_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output btkpq_pkg::out_word_t         out_word,
  input  logic                         cfg_we,
  input  logic [btkpq_pkg::CAP_W-1:0]  cfg_data
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > btkpq_pkg::CAP_W) ? CNT_W : btkpq_pkg::CAP_W;

  logic [btkpq_pkg::CAP_W-1:0] cap_r;
  logic [CNT_W-1:0]            count_r;
  logic [CNT_W-1:0]            count_nxt;
  logic                        out_valid_r;
  btkpq_pkg::out_word_t        out_word_r;
  btkpq_pkg::out_word_t        out_word_nxt;

  logic                        in_acc;
  logic                        is_remove;
  logic                        full;
  logic                        empty;
  logic [CMP_W-1:0]            count_ext;
  logic [CMP_W-1:0]            occ_ext;
  btkpq_pkg::cell_ctrl_t       ctrl;
  btkpq_pkg::entry_t           new_entry;

  btkpq_pkg::entry_t           cell_entry [MAX_ENTRIES];
  logic                        cell_ahead [MAX_ENTRIES];

  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign is_remove = (in_word.mode == btkpq_pkg::MODE_REMOVE);

  assign count_ext = CMP_W'(count_r);
  assign full      = (count_ext >= CMP_W'(cap_r)) || (count_ext >= CMP_W'(MAX_ENTRIES));
  assign empty     = (count_r == '0);

  assign new_entry.id  = in_word.entry_id;
  assign new_entry.key = in_word.entry_key;
  assign new_entry.seq = in_word.entry_seq;

  assign ctrl.ins_en = in_acc && !is_remove && !full;
  assign ctrl.rem_en = in_acc && is_remove && !empty;

  generate
    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      btkpq_pkg::entry_t prev_e;
      btkpq_pkg::entry_t next_e;
      logic              prev_b;

      if (i == 0) begin : g_first
        assign prev_e = new_entry;
        assign prev_b = 1'b0;
      end else begin : g_mid
        assign prev_e = cell_entry[i-1];
        assign prev_b = cell_ahead[i-1];
      end

      if (i == MAX_ENTRIES - 1) begin : g_last
        assign next_e = cell_entry[i];
      end else begin : g_inner
        assign next_e = cell_entry[i+1];
      end

      btkpq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .new_entry   (new_entry),
        .occupied    (CNT_W'(i) < count_r),
        .prev_entry  (prev_e),
        .prev_ahead  (prev_b),
        .next_entry  (next_e),
        .entry_q     (cell_entry[i]),
        .ahead       (cell_ahead[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins_en) begin
      count_nxt = count_r + 1'b1;
    end else if (ctrl.rem_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  assign occ_ext = CMP_W'(count_nxt);

  always_comb begin
    out_word_nxt           = '0;
    out_word_nxt.occupancy = occ_ext[btkpq_pkg::OCC_W-1:0];
    if (!is_remove) begin
      out_word_nxt.status = full ? btkpq_pkg::ST_FULL : btkpq_pkg::ST_INSERTED;
    end else if (empty) begin
      out_word_nxt.status = btkpq_pkg::ST_EMPTY;
    end else begin
      // The head cell always holds the best entry.
      out_word_nxt.status  = btkpq_pkg::ST_REMOVED;
      out_word_nxt.out_id  = cell_entry[0].id;
      out_word_nxt.out_key = cell_entry[0].key;
      out_word_nxt.out_seq = cell_entry[0].seq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= btkpq_pkg::CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      count_r <= count_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `BTKPQ_ASSERT_NOW(a_count_bound, 1'b1, count_ext <= CMP_W'(MAX_ENTRIES), "count above depth")
  `BTKPQ_ASSERT_NEXT(a_insert_grows, ctrl.ins_en, count_r == $past(count_r) + 1'b1, "no growth")
  `BTKPQ_ASSERT_NEXT(a_remove_status, ctrl.rem_en, out_word_r.status == 2'd2, "bad remove")
  `BTKPQ_ASSERT_NOW(a_head_sorted, count_r >= CNT_W'(2), cell_entry[0].key >= cell_entry[1].key, "unsorted")

endmodule

// ===== hdl/btkpq_cell.sv =====
// ----------------------------------------------------------------------------
// Priority queue cell
// Holds one entry of the sorted row; takes the new entry, its upper
// neighbor's entry or its lower neighbor's entry as the command requires.
// ----------------------------------------------------------------------------
module btkpq_cell (
  input  logic                  clk,
  input  btkpq_pkg::cell_ctrl_t ctrl,
  input  btkpq_pkg::entry_t     new_entry,
  input  logic                  occupied,
  input  btkpq_pkg::entry_t     prev_entry,
  input  logic                  prev_ahead,
  input  btkpq_pkg::entry_t     next_entry,
  output btkpq_pkg::entry_t     entry_q,
  output logic                  ahead
);

  btkpq_pkg::entry_t entry_r;
  btkpq_pkg::entry_t entry_nxt;

  // The new entry goes ahead of this one on a larger key, or on an equal key
  // with a smaller sequence. Full ties stay behind, which keeps insertion order.
  assign ahead = !occupied ||
                 (new_entry.key > entry_r.key) ||
                 ((new_entry.key == entry_r.key) && (new_entry.seq < entry_r.seq));

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins_en && ahead) begin
      entry_nxt = prev_ahead ? prev_entry : new_entry;
    end else if (ctrl.rem_en) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_q = entry_r;

endmodule

// ===== tb/bounded_two_key_priority_queue_core_tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the bounded two-key priority queue core
// Drives insert and remove words through the valid/stall input channel and
// checks every result word against a behavioral queue kept in insertion
// order. A short directed plan covers the edge cases, then random phases
// vary capacity, insert/remove mix, sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module bounded_two_key_priority_queue_core_tb;

  localparam int MAX_ENTRIES  = btkpq_pkg::MAX_ENTRIES_DEF;
  localparam int CAP_W        = btkpq_pkg::CAP_W;
  localparam int OCC_W        = btkpq_pkg::OCC_W;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 300;

  typedef struct {
    bit                   is_cap;
    logic [CAP_W-1:0]     cap;
    btkpq_pkg::in_word_t  word;
    bit                   typed;
    btkpq_pkg::out_word_t want;
  } plan_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  btkpq_pkg::in_word_t  in_word;
  logic                 out_valid;
  logic                 out_stall;
  btkpq_pkg::out_word_t out_word;
  logic                 cfg_we;
  logic [CAP_W-1:0]     cfg_data;

  // Behavioral queue state and the results it still owes.
  btkpq_pkg::entry_t    held_entries[$];
  logic [CAP_W-1:0]     cap_reg;
  btkpq_pkg::out_word_t pending_results[$];
  plan_row_t            plan[$];

  int fails        = 0;
  int words_sent   = 0;
  int results_seen = 0;
  int full_seen    = 0;
  int empty_seen   = 0;
  int cycles       = 0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_left    = 0;
  bit hold_req     = 1'b0;

  bounded_two_key_priority_queue_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Long receiver hold-off, loaded when the stimulus asks for one.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end
  end

  function automatic btkpq_pkg::out_word_t predict_queue_op(btkpq_pkg::in_word_t w);
    btkpq_pkg::out_word_t r;
    btkpq_pkg::entry_t    e;
    int                   limit;
    int                   best;
    r = '0;
    if (w.mode == btkpq_pkg::MODE_INSERT) begin
      limit = (int'(cap_reg) < MAX_ENTRIES) ? int'(cap_reg) : MAX_ENTRIES;
      if (held_entries.size() >= limit) begin
        r.status = btkpq_pkg::ST_FULL;
      end else begin
        e.id  = w.entry_id;
        e.key = w.entry_key;
        e.seq = w.entry_seq;
        held_entries.push_back(e);
        r.status = btkpq_pkg::ST_INSERTED;
      end
    end else if (held_entries.size() == 0) begin
      r.status = btkpq_pkg::ST_EMPTY;
    end else begin
      // Strict compares keep the earliest inserted entry on a full tie.
      best = 0;
      for (int i = 1; i < held_entries.size(); i++) begin
        if (held_entries[i].key > held_entries[best].key ||
            (held_entries[i].key == held_entries[best].key &&
             held_entries[i].seq < held_entries[best].seq))
          best = i;
      end
      e = held_entries[best];
      held_entries.delete(best);
      r.status  = btkpq_pkg::ST_REMOVED;
      r.out_id  = e.id;
      r.out_key = e.key;
      r.out_seq = e.seq;
    end
    r.occupancy = OCC_W'(held_entries.size());
    return r;
  endfunction

  function automatic btkpq_pkg::in_word_t mk_word(btkpq_pkg::mode_t m, int id, int key,
                                                  int seq);
    btkpq_pkg::in_word_t w;
    w.mode      = m;
    w.entry_id  = 8'(id);
    w.entry_key = 8'(key);
    w.entry_seq = 16'(seq);
    return w;
  endfunction

  task automatic add_op(btkpq_pkg::mode_t m, int id, int key, int seq);
    plan_row_t row;
    row = '{default: '0};
    row.word = mk_word(m, id, key, seq);
    plan.push_back(row);
  endtask

  task automatic add_typed(btkpq_pkg::mode_t m, int id, int key, int seq,
                           btkpq_pkg::status_t st, int occ);
    plan_row_t row;
    row = '{default: '0};
    row.word = mk_word(m, id, key, seq);
    row.typed = 1'b1;
    row.want.status = st;
    row.want.occupancy = OCC_W'(occ);
    plan.push_back(row);
  endtask

  task automatic add_cap(int v);
    plan_row_t row;
    row = '{default: '0};
    row.is_cap = 1'b1;
    row.cap = CAP_W'(v);
    plan.push_back(row);
  endtask

  // Called at a rising edge; returns at the edge where the word is taken.
  task automatic send_word(btkpq_pkg::in_word_t w, bit typed, btkpq_pkg::out_word_t want);
    btkpq_pkg::out_word_t r;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!(in_valid && !in_stall));
    r = predict_queue_op(w);
    pending_results.push_back(typed ? want : r);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cap(logic [CAP_W-1:0] v);
    cfg_data <= v;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cap_reg = v;
  endtask

  task automatic run_phase(int cap, int n, int ins_pct, int idle_pct, int stall_pct);
    btkpq_pkg::in_word_t  w;
    btkpq_pkg::out_word_t none;
    none = '0;
    wait_drained();
    write_cap(CAP_W'(cap));
    snd_idle_pct  = idle_pct;
    rcv_stall_pct = stall_pct;
    for (int k = 0; k < n; k++) begin
      w.mode      = ($urandom_range(99) < ins_pct) ? btkpq_pkg::MODE_INSERT
                                                   : btkpq_pkg::MODE_REMOVE;
      w.entry_id  = 8'($urandom_range(255));
      // A few key and sequence values recur often so that ties are common.
      w.entry_key = 8'(($urandom_range(2) == 0) ? $urandom_range(255)
                                                : 32'h80 + 32'h7f * $urandom_range(1));
      w.entry_seq = 16'(($urandom_range(1) == 0) ? $urandom_range(65535)
                                                 : $urandom_range(3));
      send_word(w, 1'b0, none);
    end
  endtask

  always @(posedge clk) begin
    btkpq_pkg::out_word_t exp;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_word.status == btkpq_pkg::ST_FULL) full_seen++;
        if (out_word.status == btkpq_pkg::ST_EMPTY) empty_seen++;
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected: %h", out_word);
          fails++;
        end else begin
          exp = pending_results.pop_front();
          if (out_word.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, out_word.status);
            fails++;
          end
          if (out_word.out_id !== exp.out_id) begin
            $error("out_id: expected %0d, got %0d", exp.out_id, out_word.out_id);
            fails++;
          end
          if (out_word.out_key !== exp.out_key) begin
            $error("out_key: expected %0d, got %0d", exp.out_key, out_word.out_key);
            fails++;
          end
          if (out_word.out_seq !== exp.out_seq) begin
            $error("out_seq: expected %0d, got %0d", exp.out_seq, out_word.out_seq);
            fails++;
          end
          if (out_word.occupancy !== exp.occupancy) begin
            $error("occupancy: expected %0d, got %0d", exp.occupancy, out_word.occupancy);
            fails++;
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < rcv_stall_pct);
    end
  end

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_word  <= '0;
    cfg_we   <= 1'b0;
    cfg_data <= '0;
    cap_reg  = btkpq_pkg::CAP_RESET;

    // Empty queue, extreme fields, ties on key and on key plus sequence.
    add_typed(btkpq_pkg::MODE_REMOVE, 8'haa, 8'h55, 16'hffff, btkpq_pkg::ST_EMPTY, 0);
    add_typed(btkpq_pkg::MODE_INSERT, 255, 255, 65535, btkpq_pkg::ST_INSERTED, 1);
    add_typed(btkpq_pkg::MODE_INSERT, 0, 0, 0, btkpq_pkg::ST_INSERTED, 2);
    add_op(btkpq_pkg::MODE_INSERT, 8'h11, 255, 0);
    add_op(btkpq_pkg::MODE_INSERT, 8'h22, 8'h80, 5);
    add_op(btkpq_pkg::MODE_INSERT, 8'h33, 8'h80, 3);
    add_op(btkpq_pkg::MODE_INSERT, 8'h44, 8'h80, 3);
    for (int i = 0; i < 6; i++) add_op(btkpq_pkg::MODE_REMOVE, 255, 255, 65535);
    add_typed(btkpq_pkg::MODE_REMOVE, 0, 0, 0, btkpq_pkg::ST_EMPTY, 0);
    // Zero capacity rejects everything.
    add_cap(0);
    add_typed(btkpq_pkg::MODE_INSERT, 1, 2, 3, btkpq_pkg::ST_FULL, 0);
    // Fill a small queue, then lower the capacity below the count.
    add_cap(2);
    add_typed(btkpq_pkg::MODE_INSERT, 5, 9, 7, btkpq_pkg::ST_INSERTED, 1);
    add_typed(btkpq_pkg::MODE_INSERT, 6, 9, 7, btkpq_pkg::ST_INSERTED, 2);
    add_typed(btkpq_pkg::MODE_INSERT, 7, 200, 1, btkpq_pkg::ST_FULL, 2);
    add_cap(1);
    add_typed(btkpq_pkg::MODE_INSERT, 8, 1, 1, btkpq_pkg::ST_FULL, 2);
    add_op(btkpq_pkg::MODE_REMOVE, 0, 0, 0);
    add_typed(btkpq_pkg::MODE_INSERT, 9, 1, 1, btkpq_pkg::ST_FULL, 1);
    add_op(btkpq_pkg::MODE_REMOVE, 0, 0, 0);
    add_typed(btkpq_pkg::MODE_INSERT, 10, 3, 4, btkpq_pkg::ST_INSERTED, 1);
    add_op(btkpq_pkg::MODE_REMOVE, 0, 0, 0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cap) begin
        wait_drained();
        write_cap(plan[i].cap);
      end else begin
        send_word(plan[i].word, plan[i].typed, plan[i].want);
      end
    end

    // Capacity at and above the store size, then lowered step by step to zero.
    run_phase(16, 300, 60, 0, 0);
    run_phase(31, 250, 70, 87, 0);
    run_phase(4, 250, 55, 0, 87);
    run_phase(1, 200, 50, 17, 17);
    run_phase(0, 60, 50, 0, 0);

    // The receiver holds off while words keep coming, so the input stalls.
    wait_drained();
    write_cap(CAP_W'(16));
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    run_phase(16, 60, 70, 0, 0);

    run_phase(9, 250, 45, 17, 17);
    run_phase(16, 300, 65, 0, 0);
    run_phase(31, 200, 35, 87, 87);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("%0d words sent and %0d results checked across capacities 0 to 31;",
             words_sent, results_seen);
    $display("%0d inserts rejected as full, %0d removes on an empty queue.",
             full_seen, empty_seen);
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/btkpq_pkg.sv
hdl/btkpq_cell.sv
hdl/bounded_two_key_priority_queue_core.sv
tb/bounded_two_key_priority_queue_core_tb.sv
